// File: hdl/quaternion_to_euler_xzy_assert.svh
// ----------------------------------------------------------------------------
// Quaternion to Euler assertion macros
// Clocked assertion helpers used by the conversion pipeline.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_XZY_ASSERT_SVH
`define QUATERNION_TO_EULER_XZY_ASSERT_SVH

// Checked on every rising edge while out of reset
`define Q2E_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included
`define Q2E_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: hdl/q2e_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler package
// Widths, constants, types and rounding shared by the conversion pipeline.
// ----------------------------------------------------------------------------
package q2e_pkg;

  // Algorithm constants
  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int TAB_LEN         = 24;
  localparam int NSTEP = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
  localparam int SQ_STEPS        = 31;  // one result bit per stage

  // Widths
  localparam int QW  = 16;  // quaternion component
  localparam int PW  = 32;  // component product, Q.30
  localparam int XW  = 36;  // CORDIC vector coordinate
  localparam int ZW  = 34;  // CORDIC angle accumulator, Q.30
  localparam int HW  = 36;  // angle before rounding (pole heading is 2x)
  localparam int OW  = 18;  // output angle
  localparam int SW  = 32;  // saturated asin operand
  localparam int RW  = 62;  // square root remainder and root
  localparam int RND_SH = 30 - ANGLE_FRAC_BITS;
  localparam int OUT_MAX = 2 ** (OW - 1) - 1;
  localparam int OUT_MIN = -(2 ** (OW - 1));

  localparam logic signed [ZW-1:0] HALF_PI = 34'sd1686629713;
  localparam logic signed [XW-1:0] ONE_Q30 = 36'sd1073741824;

  // atan(2^-i) in Q.30, truncated
  localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  // Register map
  localparam logic REG_POLE_THR = 1'b0;
  localparam logic [14:0] THR_RESET = 15'd16351;

  typedef enum logic [1:0] {
    POLE_NONE  = 2'd0,
    POLE_NORTH = 2'd1,
    POLE_SOUTH = 2'd2
  } pole_e;

  // One CORDIC lane stage
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } lane_t;

  // Operands carried alongside the square root
  typedef struct packed {
    logic signed [XW-1:0] hx;
    logic signed [XW-1:0] hy;
    logic signed [XW-1:0] bx;
    logic signed [XW-1:0] by;
    logic signed [SW-1:0] s;
    pole_e                pc;
  } side_t;

  // Round half up from Q.30 and saturate to the output range
  function automatic logic signed [OW-1:0] round_sat(input logic signed [HW-1:0] v);
    logic signed [HW:0] t;
    logic signed [HW:0] r;
    t = (HW+1)'(v) + $signed((HW+1)'(1) << (RND_SH - 1));
    r = t >>> RND_SH;
    if (r > (HW+1)'(OUT_MAX)) begin
      return OW'(OUT_MAX);
    end else if (r < (HW+1)'(OUT_MIN)) begin
      return OW'(OUT_MIN);
    end
    return OW'(r);
  endfunction

  localparam logic signed [OW-1:0] ATT_POLE_OUT = round_sat(HW'(HALF_PI));

endpackage

// File: hdl/q2e_cordic_lane.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler CORDIC lane
// Pipelined vectoring CORDIC: atan2(y, x) in Q.30, one iteration per stage.
// ----------------------------------------------------------------------------
module q2e_cordic_lane (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [q2e_pkg::XW-1:0]   y_i,
  input  logic signed [q2e_pkg::XW-1:0]   x_i,
  output logic signed [q2e_pkg::ZW-1:0]   angle_o,
  output logic                            zero_o
);

  q2e_pkg::lane_t st_q [q2e_pkg::NSTEP+1];
  q2e_pkg::lane_t pre_d;

  // Pre-rotation of the left half plane by +-pi/2
  always_comb begin
    pre_d.zero = (x_i == '0) && (y_i == '0);
    pre_d.x    = x_i;
    pre_d.y    = y_i;
    pre_d.z    = '0;
    if (x_i[q2e_pkg::XW-1]) begin
      if (!y_i[q2e_pkg::XW-1]) begin
        pre_d.x = y_i;
        pre_d.y = -x_i;
        pre_d.z = q2e_pkg::HALF_PI;
      end else begin
        pre_d.x = -y_i;
        pre_d.y = x_i;
        pre_d.z = -q2e_pkg::HALF_PI;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= pre_d;
    end
  end

  // Iteration stages
  for (genvar k = 0; k < q2e_pkg::NSTEP; k++) begin : g_step
    localparam logic signed [q2e_pkg::ZW-1:0] ANG =
      $signed(q2e_pkg::ZW'(q2e_pkg::ATAN_TAB[k]));
    q2e_pkg::lane_t nxt_d;
    logic signed [q2e_pkg::XW-1:0] xs;
    logic signed [q2e_pkg::XW-1:0] ys;

    always_comb begin
      xs = st_q[k].x >>> k;
      ys = st_q[k].y >>> k;
      nxt_d.zero = st_q[k].zero;
      if (!st_q[k].y[q2e_pkg::XW-1]) begin
        nxt_d.x = st_q[k].x + ys;
        nxt_d.y = st_q[k].y - xs;
        nxt_d.z = st_q[k].z + ANG;
      end else begin
        nxt_d.x = st_q[k].x - ys;
        nxt_d.y = st_q[k].y + xs;
        nxt_d.z = st_q[k].z - ANG;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k+1] <= nxt_d;
      end
    end
  end

  assign angle_o = st_q[q2e_pkg::NSTEP].z;
  assign zero_o  = st_q[q2e_pkg::NSTEP].zero;

endmodule

// File: hdl/quaternion_to_euler_xzy.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler (heading / attitude / bank) converter
// Pipeline: 4 product/operand stages, 31 square-root stages, 17 CORDIC stages
// and 1 output stage between an accepted input transaction and its result.
// Throughput: one quaternion per cycle; the whole pipeline halts on output stall.
// Reset: async active low clears all valid bits; pole_threshold returns to 16351.
// ----------------------------------------------------------------------------
`include "quaternion_to_euler_xzy_assert.svh"

module quaternion_to_euler_xzy (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z (16 bits each)
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // heading_angle, attitude_angle, bank_angle (18 each), pad
  output logic [1:0]  m_tuser,   // pole_case
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LAT = 4 + q2e_pkg::SQ_STEPS + q2e_pkg::NSTEP + 2;
  localparam int SQ_TOP = q2e_pkg::SQ_STEPS;
  localparam int SD_TOP = q2e_pkg::SQ_STEPS + 2;

  logic en;
  logic [LAT-1:0] vld_q;
  logic [14:0] pole_thr_q;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == q2e_pkg::REG_POLE_THR) ? {17'b0, pole_thr_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pole_thr_q <= q2e_pkg::THR_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == q2e_pkg::REG_POLE_THR)) begin
      pole_thr_q <= pwdata[14:0];
    end
  end

  // Pipeline advance and valid bits
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_tvalid};
    end
  end

  // Stage A: component products
  logic signed [q2e_pkg::QW-1:0] qw, qx, qy, qz;
  logic signed [q2e_pkg::QW-1:0] w_a_q, x_a_q;
  logic signed [q2e_pkg::PW-1:0] p_xy_q, p_zw_q, p_yw_q, p_xz_q, p_yy_q;
  logic signed [q2e_pkg::PW-1:0] p_zz_q, p_xw_q, p_yz_q, p_xx_q;

  assign qw = $signed(s_tdata[15:0]);
  assign qx = $signed(s_tdata[31:16]);
  assign qy = $signed(s_tdata[47:32]);
  assign qz = $signed(s_tdata[63:48]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_a_q  <= qw;
      x_a_q  <= qx;
      p_xy_q <= qx * qy;
      p_zw_q <= qz * qw;
      p_yw_q <= qy * qw;
      p_xz_q <= qx * qz;
      p_yy_q <= qy * qy;
      p_zz_q <= qz * qz;
      p_xw_q <= qx * qw;
      p_yz_q <= qy * qz;
      p_xx_q <= qx * qx;
    end
  end

  // Stage B: test value, pole decision, CORDIC operands
  q2e_pkg::side_t side_q [SD_TOP+1];
  q2e_pkg::side_t side_b_d;
  logic signed [32:0] test_b, thr_b;
  logic signed [33:0] s_wide, d_h, d_b, sum_h, sum_b;

  always_comb begin
    test_b = 33'(p_xy_q) + 33'(p_zw_q);
    thr_b  = $signed({3'b0, pole_thr_q, 15'b0});
    s_wide = 34'(test_b) <<< 1;
    d_h    = 34'(p_yw_q) - 34'(p_xz_q);
    d_b    = 34'(p_xw_q) - 34'(p_yz_q);
    sum_h  = 34'(p_yy_q) + 34'(p_zz_q);
    sum_b  = 34'(p_xx_q) + 34'(p_zz_q);

    if (s_wide > 34'sd1073741824) begin
      side_b_d.s = 32'sd1073741824;
    end else if (s_wide < -34'sd1073741824) begin
      side_b_d.s = -32'sd1073741824;
    end else begin
      side_b_d.s = 32'(s_wide);
    end

    side_b_d.hy = q2e_pkg::XW'(d_h) <<< 1;
    side_b_d.hx = q2e_pkg::ONE_Q30 - (q2e_pkg::XW'(sum_h) <<< 1);
    side_b_d.by = q2e_pkg::XW'(d_b) <<< 1;
    side_b_d.bx = q2e_pkg::ONE_Q30 - (q2e_pkg::XW'(sum_b) <<< 1);
    side_b_d.pc = q2e_pkg::POLE_NONE;

    if (test_b > thr_b) begin
      side_b_d.pc = q2e_pkg::POLE_NORTH;
    end else if (test_b < -thr_b) begin
      side_b_d.pc = q2e_pkg::POLE_SOUTH;
    end
    // at a pole the heading lane works on atan2(x, w)
    if (side_b_d.pc != q2e_pkg::POLE_NONE) begin
      side_b_d.hy = q2e_pkg::XW'(x_a_q);
      side_b_d.hx = q2e_pkg::XW'(w_a_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_b_d;
    end
  end

  // Stage C: square of the asin operand
  logic [30:0] s_abs;
  logic [q2e_pkg::RW-1:0] s2_c_q;

  assign s_abs = side_q[0].s[q2e_pkg::SW-1] ? 31'(-side_q[0].s) : 31'(side_q[0].s);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_c_q    <= q2e_pkg::RW'(s_abs) * q2e_pkg::RW'(s_abs);
      side_q[1] <= side_q[0];
    end
  end

  // Stage D: radicand 1 - s^2
  logic [q2e_pkg::RW-1:0] sq_n_q [SQ_TOP+1];
  logic [q2e_pkg::RW-1:0] sq_r_q [SQ_TOP+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_n_q[0] <= (q2e_pkg::RW'(1) << 60) - s2_c_q;
      sq_r_q[0] <= '0;
      side_q[2] <= side_q[1];
    end
  end

  // Square root, one result bit per stage
  for (genvar k = 0; k < q2e_pkg::SQ_STEPS; k++) begin : g_sqrt
    localparam logic [q2e_pkg::RW-1:0] BIT =
      q2e_pkg::RW'(1) << (2 * (q2e_pkg::SQ_STEPS - 1 - k));
    logic [q2e_pkg::RW-1:0] trial;
    logic [q2e_pkg::RW-1:0] n_d, r_d;

    always_comb begin
      trial = sq_r_q[k] + BIT;
      if (sq_n_q[k] >= trial) begin
        n_d = sq_n_q[k] - trial;
        r_d = (sq_r_q[k] >> 1) + BIT;
      end else begin
        n_d = sq_n_q[k];
        r_d = sq_r_q[k] >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_n_q[k+1]   <= n_d;
        sq_r_q[k+1]   <= r_d;
        side_q[k+3]   <= side_q[k+2];
      end
    end
  end

  // CORDIC lanes
  logic signed [q2e_pkg::ZW-1:0] z_head, z_att, z_bank;
  logic zero_head, zero_att, zero_bank;
  q2e_pkg::pole_e pc_q [q2e_pkg::NSTEP+1];

  q2e_cordic_lane u_head (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (side_q[SD_TOP].hy),
    .x_i     (side_q[SD_TOP].hx),
    .angle_o (z_head),
    .zero_o  (zero_head)
  );

  q2e_cordic_lane u_att (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (q2e_pkg::XW'(side_q[SD_TOP].s)),
    .x_i     ($signed(q2e_pkg::XW'(sq_r_q[SQ_TOP]))),
    .angle_o (z_att),
    .zero_o  (zero_att)
  );

  q2e_cordic_lane u_bank (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (side_q[SD_TOP].by),
    .x_i     (side_q[SD_TOP].bx),
    .angle_o (z_bank),
    .zero_o  (zero_bank)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      pc_q[0] <= side_q[SD_TOP].pc;
    end
  end

  for (genvar k = 0; k < q2e_pkg::NSTEP; k++) begin : g_pc
    always_ff @(posedge clk_i) begin
      if (en) begin
        pc_q[k+1] <= pc_q[k];
      end
    end
  end

  // Output stage: case selection, rounding, saturation
  logic signed [q2e_pkg::HW-1:0] head_w, att_w, bank_w, zh;
  logic signed [q2e_pkg::OW-1:0] head_q, att_q, bank_q;
  q2e_pkg::pole_e pc_o_q;
  q2e_pkg::pole_e pc_l;

  assign pc_l = pc_q[q2e_pkg::NSTEP];

  always_comb begin
    zh     = zero_head ? '0 : q2e_pkg::HW'(z_head);
    head_w = zh;
    att_w  = zero_att ? '0 : q2e_pkg::HW'(z_att);
    bank_w = zero_bank ? '0 : q2e_pkg::HW'(z_bank);
    case (pc_l)
      q2e_pkg::POLE_NORTH: begin
        head_w = zh <<< 1;
        att_w  = q2e_pkg::HW'(q2e_pkg::HALF_PI);
        bank_w = '0;
      end
      q2e_pkg::POLE_SOUTH: begin
        head_w = -(zh <<< 1);
        att_w  = -q2e_pkg::HW'(q2e_pkg::HALF_PI);
        bank_w = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      head_q <= q2e_pkg::round_sat(head_w);
      att_q  <= q2e_pkg::round_sat(att_w);
      bank_q <= q2e_pkg::round_sat(bank_w);
      pc_o_q <= pc_l;
    end
  end

  assign m_tdata = {2'b00, bank_q, att_q, head_q};
  assign m_tuser = pc_o_q;

  // Assertions
  `Q2E_ASSERT_ALWAYS(a_rst_no_valid, !rst_ni |=> !m_tvalid, "valid output after reset edge")
  `Q2E_ASSERT(a_stall_holds, !en |=> $stable(vld_q), "pipeline valid bits moved while stalled")
  `Q2E_ASSERT(a_pole_bank_zero, m_tvalid && (m_tuser != q2e_pkg::POLE_NONE) |-> m_tdata[53:36] == '0, "bank nonzero at a pole")
  `Q2E_ASSERT(a_north_att, m_tvalid && (m_tuser == q2e_pkg::POLE_NORTH) |-> $signed(m_tdata[35:18]) == q2e_pkg::ATT_POLE_OUT, "north pole attitude not pi/2")

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler converter testbench
// Drives quaternions through the stream input, predicts heading, attitude,
// bank and pole case with a fixed-point CORDIC model, and checks each result
// in order. The pole threshold is reprogrammed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic signed [17:0] head;
    logic signed [17:0] att;
    logic signed [17:0] bank;
    q2e_pkg::pole_e     pc;
  } euler_t;

  // atan(2^-i) in Q.30, truncated
  localparam longint ATAN_Q30 [24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };
  localparam longint HALF_PI_Q30 = 64'd1686629713;
  localparam longint ONE_Q = 64'd1073741824;
  localparam int FRAC = 13;
  localparam int STEPS = 16;
  localparam int PIPE_LAT = 53;
  localparam int WATCHDOG = 20000;

  // ---------------------------------------------------------------------------
  // Prediction helpers
  function automatic longint floor_shr(longint v, int s);
    if (v >= 0) return v >> s;
    return -(((-v) - 1) >> s) - 1;
  endfunction

  function automatic longint root_floor(longint n);
    longint res, b;
    res = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  function automatic longint vec_atan2(longint y, longint x);
    longint z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    // move the left half plane over by a quarter turn
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HALF_PI_Q30;
      end else begin
        t = x; x = -y; y = t; z = -HALF_PI_Q30;
      end
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += ATAN_Q30[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_Q30[i];
      end
    end
    return z;
  endfunction

  function automatic logic signed [17:0] angle_out(longint q30);
    longint r;
    r = floor_shr(q30 + (64'sd1 <<< (29 - FRAC)), 30 - FRAC);
    if (r > 131071) r = 131071;
    if (r < -131072) r = -131072;
    return r[17:0];
  endfunction

  function automatic euler_t quat_to_euler(logic [63:0] q, logic [14:0] thr_q15);
    longint w, x, y, z, tst, thr, s, s2, head, att, bank;
    euler_t e;
    w = longint'($signed(q[15:0]));
    x = longint'($signed(q[31:16]));
    y = longint'($signed(q[47:32]));
    z = longint'($signed(q[63:48]));
    tst = x * y + z * w;
    thr = longint'(thr_q15) << 15;
    if (tst > thr) begin
      head = 2 * vec_atan2(x, w); att = HALF_PI_Q30; bank = 0;
      e.pc = q2e_pkg::POLE_NORTH;
    end else if (tst < -thr) begin
      head = -2 * vec_atan2(x, w); att = -HALF_PI_Q30; bank = 0;
      e.pc = q2e_pkg::POLE_SOUTH;
    end else begin
      s = 2 * tst;
      if (s > ONE_Q) s = ONE_Q;
      if (s < -ONE_Q) s = -ONE_Q;
      s2 = (s < 0) ? -s : s;
      s2 = s2 * s2;
      head = vec_atan2(2 * (y * w - x * z), ONE_Q - 2 * (y * y + z * z));
      att = vec_atan2(s, root_floor((64'sd1 <<< 60) - s2));
      bank = vec_atan2(2 * (x * w - y * z), ONE_Q - 2 * (x * x + z * z));
      e.pc = q2e_pkg::POLE_NONE;
    end
    e.head = angle_out(head);
    e.att = angle_out(att);
    e.bank = angle_out(bank);
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: expected angles in arrival order
  class euler_scoreboard;
    euler_t pending_angles[$];
    logic [14:0] thr_q15;
    int mismatches;

    function void note_quat(logic [63:0] q);
      pending_angles.push_back(quat_to_euler(q, thr_q15));
    endfunction

    function void check_angles(logic [55:0] data, logic [1:0] user);
      euler_t exp_e, got;
      got.head = data[17:0];
      got.att = data[35:18];
      got.bank = data[53:36];
      got.pc = q2e_pkg::pole_e'(user);
      if (pending_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h/%0d", data, user);
        return;
      end
      exp_e = pending_angles.pop_front();
      if (got !== exp_e || data[55:54] !== 2'b00) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp h=%0d a=%0d b=%0d pc=%0d got h=%0d a=%0d b=%0d pc=%0d",
                   exp_e.head, exp_e.att, exp_e.bank, exp_e.pc,
                   got.head, got.att, got.bank, got.pc);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // quat_w, quat_x, quat_y, quat_z
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;        // heading, attitude, bank (18 each), pad
  logic [1:0]  m_tuser;        // pole_case
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  euler_scoreboard sb = new();
  int idle_cycles = 0;
  bit stall_mode = 1'b0;

  always #5 clk_i = ~clk_i;

  quaternion_to_euler_xzy u_dut (
    .clk_i, .rst_ni, .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Output side: check results, stall on its own pattern
  always @(posedge clk_i) begin
    if (m_tvalid && m_tready) sb.check_angles(m_tdata, m_tuser);
    if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
    m_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 9) != 0);
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_threshold(logic [14:0] thr);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {q2e_pkg::REG_POLE_THR, 2'b00}; pwdata <= {17'd0, thr};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.thr_q15 = thr;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Present one quaternion; valid stays high into the next call
  task automatic send_quat(logic [63:0] q);
    s_tvalid <= 1'b1;
    s_tdata <= q;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sb.note_quat(q);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending_angles.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 5) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_comp(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 1) ? 16'h8000 : 16'h7FFF);
      default: return 16'($signed($urandom_range(0, 46340)) *
                          ($urandom_range(0, 1) ? 1 : -1));
    endcase
  endfunction

  // Random quaternions: random, extreme or bounded components, some near the poles
  function automatic logic [63:0] rand_quat();
    int kind;
    logic [15:0] a, b;
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      // pole region: x*y + z*w close to +-0.5
      a = 16'($urandom_range(20000, 26000));
      b = 16'($urandom_range(20000, 26000));
      if ($urandom_range(0, 1)) return {16'($urandom_range(0, 2000)) ^ {16{1'b0}}, b,
                                        ($urandom_range(0, 1) ? a : -a),
                                        16'($urandom_range(0, 3000))};
      return {a, 16'($urandom_range(0, 500)), 16'($urandom_range(0, 500)),
              ($urandom_range(0, 1) ? b : -b)};
    end
    return {rand_comp(kind % 3), rand_comp(kind % 3), rand_comp(kind % 3), rand_comp(kind % 3)};
  endfunction

  task automatic random_phase(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && count > 0) begin
        send_quat(rand_quat());
        burst--; count--;
      end
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    logic [63:0] directed[$];
    sb.thr_q15 = q2e_pkg::THR_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, zero vectors, both poles, negative abscissa
    directed = '{64'h0, 64'h0000_0000_0000_7FFF, 64'h0000_0000_0000_8000,
                 64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000,
                 64'h8000_7FFF_8000_7FFF, 64'h0000_0000_5A82_5A82,
                 64'h5A82_0000_0000_5A82, 64'hA57E_0000_0000_5A82,
                 64'h0000_5A82_5A82_0000, 64'h0000_5A82_A57E_0000,
                 64'h0000_4000_4000_C000, 64'h4000_4000_4000_4000,
                 64'hC000_4000_4000_4000, 64'h0000_0000_0000_0001,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'h2000_6000_2000_C000,
                 64'h5A82_0000_0000_8000};
    foreach (directed[i]) send_quat(directed[i]);
    drain();

    // Threshold sweep, extremes included
    write_threshold(15'd0);
    foreach (directed[i]) send_quat(directed[i]);
    random_phase(200);
    drain();
    write_threshold(15'd16384);
    random_phase(300);
    drain();
    write_threshold(15'h7FFF);
    random_phase(200);
    drain();
    write_threshold(15'd8192);
    random_phase(300);
    drain();
    write_threshold(q2e_pkg::THR_RESET);
    random_phase(500);
    drain();

    if (sb.mismatches == 0 && sb.pending_angles.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/q2e_pkg.sv
hdl/q2e_cordic_lane.sv
hdl/quaternion_to_euler_xzy.sv
test/tb_top.sv
